[rtl/sobel_edge_threshold_core_macros.svh]
// Assertion macros used by the port-level checker file of the Sobel edge core.
`ifndef SOBEL_EDGE_THRESHOLD_CORE_MACROS_SVH
`define SOBEL_EDGE_THRESHOLD_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SET_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("set assertion failed");

// Next-cycle implication, disabled during reset.
`define SET_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("set assertion failed");

// Next-cycle implication, active during reset too.
`define SET_ASSERT_NEXT_NORST(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("set assertion failed");

`endif

[rtl/set_pkg.sv]
// Shared constants, types and functions of the Sobel edge core.
package set_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int PIX_W     = 8;
    localparam int LINE_W    = 2 * PIX_W;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int ROW_W     = $clog2(MAX_HEIGHT);
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;
    localparam int OUT_POS_W = 10;
    localparam int GRAD_W    = 12;
    localparam int SQ_W      = 21;
    localparam int MAG_W     = 22;

    localparam logic [CFG_W-1:0] MIN_DIM      = CFG_W'(3);
    localparam logic [CFG_W-1:0] DIM_RESET    = CFG_W'(1024);
    localparam logic [MAG_W-1:0] THR_SQ_RESET = MAG_W'(70 * 70);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRESHOLD = 2'd0,
        REG_WIDTH     = 2'd1,
        REG_HEIGHT    = 2'd2
    } t_cfg_reg;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } t_pos;

    typedef struct packed {
        logic                 emit;
        logic                 border;
        logic [OUT_POS_W-1:0] row;
        logic [OUT_POS_W-1:0] col;
    } t_tag;

    typedef struct packed {
        logic                 is_edge;
        logic [OUT_POS_W-1:0] row;
        logic [OUT_POS_W-1:0] col;
    } t_result;

    function automatic logic [CFG_W-1:0] clamp_dim(input logic [CFG_W-1:0] v,
                                                   input logic [CFG_W-1:0] hi);
        logic [CFG_W-1:0] res;
        if (v < MIN_DIM) begin
            res = MIN_DIM;
        end else if (v > hi) begin
            res = hi;
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage

[rtl/set_pix_if.sv]
// Pixel input channel: valid/ready with one grayscale pixel.
interface set_pix_if;
    import set_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

[rtl/set_res_if.sv]
// Result channel: valid/ready with edge decision and centre position.
interface set_res_if;
    import set_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 is_edge;
    logic [OUT_POS_W-1:0] out_row;
    logic [OUT_POS_W-1:0] out_col;

    modport source (output valid, output is_edge, output out_row, output out_col, input ready);
    modport sink   (input valid, input is_edge, input out_row, input out_col, output ready);
endinterface

[rtl/set_pos_cnt.sv]
// Raster position counters with frame-size clamping and wrap.
module set_pos_cnt (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_step,
    input  logic [set_pkg::CFG_W-1:0] i_width,
    input  logic [set_pkg::CFG_W-1:0] i_height,
    output set_pkg::t_pos           o_pos
);
    import set_pkg::*;

    logic [ROW_W-1:0] r_row, n_row;
    logic [COL_W-1:0] r_col, n_col;
    logic [CFG_W-1:0] w, h;
    logic [ROW_W:0]   row_adj, row_inc;
    logic [COL_W:0]   col_inc;
    t_pos             cur;

    always_comb begin
        w = clamp_dim(i_width, CFG_W'(MAX_WIDTH));
        h = clamp_dim(i_height, CFG_W'(MAX_HEIGHT));

        // position left past the frame by a size change
        cur.col = r_col;
        row_adj = {1'b0, r_row};
        if (CFG_W'(r_col) >= w) begin
            cur.col = '0;
            row_adj = {1'b0, r_row} + 1'b1;
        end
        cur.row = (CFG_W'(row_adj) >= h) ? '0 : row_adj[ROW_W-1:0];

        col_inc = {1'b0, cur.col} + 1'b1;
        row_inc = {1'b0, cur.row} + 1'b1;

        n_col = r_col;
        n_row = r_row;
        if (i_step) begin
            if (CFG_W'(col_inc) >= w) begin
                n_col = '0;
                n_row = (CFG_W'(row_inc) >= h) ? '0 : row_inc[ROW_W-1:0];
            end else begin
                n_col = col_inc[COL_W-1:0];
                n_row = cur.row;
            end
        end
        o_pos = cur;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end
endmodule

[rtl/set_line_ram.sv]
// Line store RAM: one word per column holding {row r-2, row r-1}.
module set_line_ram (
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic [set_pkg::COL_W-1:0]  i_wr_addr,
    input  logic [set_pkg::LINE_W-1:0] i_wr_data,
    input  logic                       i_rd_en,
    input  logic [set_pkg::COL_W-1:0]  i_rd_addr,
    output logic [set_pkg::LINE_W-1:0] o_rd_data
);
    import set_pkg::*;

    logic [LINE_W-1:0] r_mem [MAX_WIDTH];
    logic [LINE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

[rtl/set_grad.sv]
// 3x3 window, Sobel gradients and squares, threshold compare.
module set_grad (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s1_fire,
    input  logic [set_pkg::PIX_W-1:0]  i_px,
    input  logic [set_pkg::PIX_W-1:0]  i_top,
    input  logic [set_pkg::PIX_W-1:0]  i_mid,
    input  set_pkg::t_tag              i_tag,
    input  logic                       i_s2_adv,
    input  logic [set_pkg::MAG_W-1:0]  i_thr_sq,
    output logic                       o_s2_vld,
    output set_pkg::t_result           o_result
);
    import set_pkg::*;

    // [row: older, prev, current][0: c-2, 1: c-1]
    logic [PIX_W-1:0] r_win [3][2];

    logic                      r_s2_vld;
    logic [SQ_W-1:0]           r_s2_sqx, r_s2_sqy;
    t_tag                      r_s2_tag;

    logic signed [GRAD_W-1:0]   pa, pb, pd, pe, pf, pg, pk, pm;
    logic signed [GRAD_W-1:0]   gx, gy;
    logic signed [2*GRAD_W-1:0] prod_x, prod_y;
    logic [MAG_W-1:0]           mag;

    function automatic logic signed [GRAD_W-1:0] px_ext(input logic [PIX_W-1:0] p);
        return $signed({{(GRAD_W-PIX_W){1'b0}}, p});
    endfunction

    always_comb begin
        pa = px_ext(r_win[0][0]);
        pb = px_ext(r_win[0][1]);
        pd = px_ext(i_top);
        pe = px_ext(r_win[1][0]);
        pf = px_ext(i_mid);
        pg = px_ext(r_win[2][0]);
        pk = px_ext(r_win[2][1]);
        pm = px_ext(i_px);
        gx = pa - pd + pe + pe - pf - pf + pg - pm;
        gy = pa + pb + pb + pd - pg - pk - pk - pm;
        prod_x = gx * gx;
        prod_y = gy * gy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_win[i][0] <= '0;
                r_win[i][1] <= '0;
            end
        end else if (i_s1_fire) begin
            r_win[0][0] <= r_win[0][1];
            r_win[0][1] <= i_top;
            r_win[1][0] <= r_win[1][1];
            r_win[1][1] <= i_mid;
            r_win[2][0] <= r_win[2][1];
            r_win[2][1] <= i_px;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (i_s1_fire) begin
            r_s2_vld <= i_tag.emit;
        end else if (i_s2_adv) begin
            r_s2_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s1_fire) begin
            r_s2_sqx <= prod_x[SQ_W-1:0];
            r_s2_sqy <= prod_y[SQ_W-1:0];
            r_s2_tag <= i_tag;
        end
    end

    always_comb begin
        mag              = {1'b0, r_s2_sqx} + {1'b0, r_s2_sqy};
        o_result.is_edge = r_s2_tag.border | (mag > i_thr_sq);
        o_result.row     = r_s2_tag.row;
        o_result.col     = r_s2_tag.col;
    end

    assign o_s2_vld = r_s2_vld;
endmodule

[rtl/sobel_edge_threshold_core.sv]
// Top level of the Sobel edge threshold core.
//
//  channel   dir  handshake        payload
//  i_pix     in   valid/ready      pixel[7:0]
//  o_res     out  valid/ready      is_edge, out_row[9:0], out_col[9:0]
//  i_cfg_*   in   write enable     i_cfg_idx[1:0], i_cfg_data[10:0]
//
// One pixel per cycle sustained unless the output stalls; each transfer
// passes line RAM read, gradient squares, compare into output register.
// Row 0 and column 0 of each row produce no result.
// Synchronous active-low reset clears counters, window and valid flags.
// A stalled output holds; new pixels are taken while any stage is free.
module sobel_edge_threshold_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    set_pix_if.sink                       i_pix,
    set_res_if.source                     o_res,
    input  logic                          i_cfg_we,
    input  logic [set_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [set_pkg::CFG_W-1:0]     i_cfg_data
);
    import set_pkg::*;

    logic [MAG_W-1:0] r_thr_sq;
    logic [CFG_W-1:0] r_width, r_height;
    logic [MAG_W-1:0] cfg_ext;

    logic             r_s1_vld;
    logic [PIX_W-1:0] r_s1_px;
    logic [COL_W-1:0] r_s1_col;
    t_tag             r_s1_tag;

    logic             r_out_vld;
    t_result          r_out;

    t_pos              pos;
    t_tag              tag_in;
    t_result           result;
    logic [LINE_W-1:0] rd_data;
    logic              accept, s1_adv, s1_fire, s2_adv, s2_vld;

    assign s2_adv      = !r_out_vld || o_res.ready;
    assign s1_adv      = !s2_vld || s2_adv;
    assign i_pix.ready = !r_s1_vld || s1_adv;
    assign accept      = i_pix.valid && i_pix.ready;
    assign s1_fire     = r_s1_vld && s1_adv;
    assign cfg_ext     = MAG_W'(i_cfg_data);

    always_comb begin
        tag_in.emit   = (pos.row != '0) && (pos.col != '0);
        tag_in.border = (pos.row == ROW_W'(1)) || (pos.col == COL_W'(1));
        tag_in.row    = OUT_POS_W'(pos.row - 1'b1);
        tag_in.col    = OUT_POS_W'(pos.col - 1'b1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr_sq <= THR_SQ_RESET;
            r_width  <= DIM_RESET;
            r_height <= DIM_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_THRESHOLD: r_thr_sq <= cfg_ext * cfg_ext;
                REG_WIDTH:     r_width  <= i_cfg_data;
                REG_HEIGHT:    r_height <= i_cfg_data;
                default:       ;
            endcase
        end
    end

    set_pos_cnt u_pos_cnt (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (accept),
        .i_width  (r_width),
        .i_height (r_height),
        .o_pos    (pos)
    );

    // word = {row r-2, row r-1}; write back {row r-1, current}
    set_line_ram u_line_ram (
        .i_clk     (i_clk),
        .i_wr_en   (s1_fire),
        .i_wr_addr (r_s1_col),
        .i_wr_data ({rd_data[PIX_W-1:0], r_s1_px}),
        .i_rd_en   (accept),
        .i_rd_addr (pos.col),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (accept) begin
            r_s1_vld <= 1'b1;
        end else if (s1_adv) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_px  <= i_pix.pixel;
            r_s1_col <= pos.col;
            r_s1_tag <= tag_in;
        end
    end

    set_grad u_grad (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s1_fire (s1_fire),
        .i_px      (r_s1_px),
        .i_top     (rd_data[LINE_W-1:PIX_W]),
        .i_mid     (rd_data[PIX_W-1:0]),
        .i_tag     (r_s1_tag),
        .i_s2_adv  (s2_adv),
        .i_thr_sq  (r_thr_sq),
        .o_s2_vld  (s2_vld),
        .o_result  (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s2_adv) begin
            r_out_vld <= s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_adv) begin
            r_out <= result;
        end
    end

    assign o_res.valid   = r_out_vld;
    assign o_res.is_edge = r_out.is_edge;
    assign o_res.out_row = r_out.row;
    assign o_res.out_col = r_out.col;
endmodule

[rtl/set_checker.sv]
// Port-level checker for the Sobel edge core, bound to the top level.
`include "sobel_edge_threshold_core_macros.svh"

module set_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic                          i_is_edge,
    input logic [set_pkg::OUT_POS_W-1:0] i_out_row,
    input logic [set_pkg::OUT_POS_W-1:0] i_out_col
);
    import set_pkg::*;

    `SET_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_is_edge) && $stable(i_out_row) && $stable(i_out_col))

    `SET_ASSERT_IMPL(a_border_white, i_clk, i_rst_n, i_out_valid && (i_out_row == '0 || i_out_col == '0), i_is_edge)

    `SET_ASSERT_IMPL(a_no_last_pos, i_clk, i_rst_n, i_out_valid, (i_out_row != '1) && (i_out_col != '1))

    `SET_ASSERT_NEXT_NORST(a_reset_idle, i_clk, !i_rst_n, !i_out_valid)
endmodule

bind sobel_edge_threshold_core set_checker u_set_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_is_edge   (o_res.is_edge),
    .i_out_row   (o_res.out_row),
    .i_out_col   (o_res.out_col)
);
